// ===== design/rc6_pkg.sv =====
// shared types, constants and a helper for the rc6 frame decoder
package rc6_pkg;

  localparam int TS_W    = 16;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BITS_PER_FRAME = 16;
  localparam int BCNT_W  = 5;
  localparam int WIN_W   = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HIGH   = 3'd4;

  localparam logic [TS_W-1:0] SHORT_LOW_RST  = 16'd320;
  localparam logic [TS_W-1:0] SHORT_HIGH_RST = 16'd590;
  localparam logic [TS_W-1:0] LONG_LOW_RST   = 16'd750;
  localparam logic [TS_W-1:0] LONG_HIGH_RST  = 16'd1150;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_LEADER1 = 4'd1,
    PH_LEADER2 = 4'd2,
    PH_S1      = 4'd3,
    PH_S2      = 4'd4,
    PH_H1      = 4'd5,
    PH_H2      = 4'd6,
    PH_H3      = 4'd7,
    PH_H4      = 4'd8,
    PH_H5      = 4'd9,
    PH_T1      = 4'd10,
    PH_T2      = 4'd11,
    PH_DATA    = 4'd12
  } phase_t;

  // exclusive window test
  function automatic logic in_win(input logic [WIN_W-1:0] len, input logic [WIN_W-1:0] lo,
                                  input logic [WIN_W-1:0] hi);
    in_win = (len > lo) && (len < hi);
  endfunction

endpackage

// ===== design/rc6_in_if.sv =====
// edge item channel
interface rc6_in_if import rc6_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [TS_W-1:0] timestamp;
  logic            level;

  modport source (output valid, output kind, output timestamp, output level, input ready);
  modport sink (input valid, input kind, input timestamp, input level, output ready);
endinterface

// ===== design/rc6_out_if.sv =====
// decoded frame channel
interface rc6_out_if import rc6_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] command;
  logic [BYTE_W-1:0] control;
  logic              repeated;

  modport source (output valid, output command, output control, output repeated, input ready);
  modport sink (input valid, input command, input control, input repeated, output ready);
endinterface

// ===== design/rc6_ir_frame_decoder_top.sv =====
// rc6 mode-0 infrared frame decoder, top level
// Takes timestamped pin edges (or unlock beats) on pin and returns one beat on frame per good
// frame unless locked: command, control and a repeat flag. An accepted beat sits in an input
// register, is classified and walked once the output register can take its result, so one beat
// per cycle is sustained; the only hold-up is a result beat still waiting on frame.ready, which
// stalls the input register behind it. Window bounds and the lock enable go in on wr_en/wr_index/
// wr_data; the user must write them only while no beat is in flight, as the block does not check.
module rc6_ir_frame_decoder_top import rc6_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  rc6_in_if.sink                pin,
  rc6_out_if.source             frame,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  logic            lock_enable;
  logic [TS_W-1:0] short_low, short_high, long_low, long_high;

  logic            s_valid;
  logic            s_kind;
  logic [TS_W-1:0] s_ts;
  logic            s_level;

  phase_t              phase, phase_next;
  logic [TS_W-1:0]     last_time, last_time_next;
  logic                half_flag, half_flag_next;
  logic [BCNT_W-1:0]   bit_count, bit_count_next;
  logic [BYTE_W-1:0]   command_shift, command_shift_next;
  logic [BYTE_W-1:0]   control_shift, control_shift_next;
  logic                toggle_bit, toggle_bit_next;
  logic                prior_toggle;
  logic [BYTE_W-1:0]   prior_command;
  logic                locked, locked_next;

  logic                out_valid;
  logic [BYTE_W-1:0]   out_command, out_control;
  logic                out_repeated;

  logic                proc;
  logic                done;
  logic                emit;
  logic [BYTE_W-1:0]   cmd_new, ctl_new;
  logic                res_repeated;

  logic [TS_W-1:0]     len;
  logic [WIN_W-1:0]    len_w, dlen_w;
  logic [WIN_W-1:0]    sl_w, sh_w, ll_w, lh_w, lead_lo, lead_hi, sl_lo, sl_hi;
  logic                sh, lg, slg, lead, sh_d, lg_d;

  assign proc      = s_valid && (!out_valid || frame.ready);
  assign pin.ready = !s_valid || proc;

  assign frame.valid    = out_valid;
  assign frame.command  = out_command;
  assign frame.control  = out_control;
  assign frame.repeated = out_repeated;

  // interval windows
  assign len     = s_ts - last_time;
  assign len_w   = {2'b00, len};
  assign sl_w    = {2'b00, short_low};
  assign sh_w    = {2'b00, short_high};
  assign ll_w    = {2'b00, long_low};
  assign lh_w    = {2'b00, long_high};
  assign lead_lo = ll_w + {1'b0, long_low, 1'b0};
  assign lead_hi = lh_w + {1'b0, long_high, 1'b0};
  assign sl_lo   = sl_w + ll_w;
  assign sl_hi   = sh_w + lh_w;
  assign sh      = in_win(len_w, sl_w, sh_w);
  assign lg      = in_win(len_w, ll_w, lh_w);
  assign slg     = in_win(len_w, sl_lo, sl_hi);
  assign lead    = in_win(len_w, lead_lo, lead_hi);

  // next state
  always_comb begin
    logic entry;
    logic hf;
    logic bad;
    logic [BCNT_W-1:0] bc;
    entry = 1'b0;
    hf = half_flag;
    bad = 1'b0;
    bc = bit_count;
    dlen_w = len_w;
    phase_next = phase;
    last_time_next = last_time;
    half_flag_next = half_flag;
    bit_count_next = bit_count;
    command_shift_next = command_shift;
    control_shift_next = control_shift;
    toggle_bit_next = toggle_bit;
    locked_next = locked;
    cmd_new = command_shift;
    ctl_new = control_shift;
    done = 1'b0;
    sh_d = 1'b0;
    lg_d = 1'b0;
    if (s_kind == KIND_UNLOCK) begin
      locked_next = 1'b0;
    end else begin
      last_time_next = s_ts;
      unique case (phase)
        PH_IDLE:    if (lead && s_level) phase_next = PH_LEADER1; else bad = 1'b1;
        PH_LEADER1: if (lg && !s_level) phase_next = PH_LEADER2; else bad = 1'b1;
        PH_LEADER2: if (sh && s_level) phase_next = PH_S1; else bad = 1'b1;
        PH_S1:      if (lg && !s_level) phase_next = PH_S2; else bad = 1'b1;
        PH_S2:      if (sh && s_level) phase_next = PH_H1; else bad = 1'b1;
        PH_H1:      if (sh && !s_level) phase_next = PH_H2; else bad = 1'b1;
        PH_H2:      if (sh && s_level) phase_next = PH_H3; else bad = 1'b1;
        PH_H3:      if (sh && !s_level) phase_next = PH_H4; else bad = 1'b1;
        PH_H4: begin
          priority if (sh && s_level) begin
            phase_next = PH_H5;
            toggle_bit_next = 1'b0;
          end else if (slg && s_level) begin
            phase_next = PH_T1;
            toggle_bit_next = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_H5:      if (lg && !s_level) phase_next = PH_T1; else bad = 1'b1;
        PH_T1: begin
          priority if (lg) phase_next = PH_T2;
          else if (slg) entry = 1'b1;
          else bad = 1'b1;
        end
        PH_T2:      if (sh) entry = 1'b1; else bad = 1'b1;
        PH_DATA:    entry = 1'b0;
        default:    bad = 1'b1;
      endcase
      // data half-bit, also taken by the edge that leaves the toggle bit
      if (entry || phase == PH_DATA) begin
        if (entry) begin
          hf = 1'b1;
          dlen_w = ll_w + {{(WIN_W-1){1'b0}}, 1'b1};
        end
        sh_d = in_win(dlen_w, sl_w, sh_w);
        lg_d = in_win(dlen_w, ll_w, lh_w);
        phase_next = PH_DATA;
        if (sh_d) hf = !hf;
        if (!sh_d && !lg_d) begin
          bad = 1'b1;
        end else begin
          if (hf) begin
            if (bit_count >= BCNT_W'(BYTE_W)) cmd_new = {command_shift[BYTE_W-2:0], s_level};
            else ctl_new = {control_shift[BYTE_W-2:0], s_level};
            bc = bit_count + 1'b1;
          end
          half_flag_next = hf;
          bit_count_next = bc;
          command_shift_next = cmd_new;
          control_shift_next = ctl_new;
          if (bc == BCNT_W'(BITS_PER_FRAME)) begin
            done = 1'b1;
            bad = 1'b1;
            if (lock_enable) locked_next = 1'b1;
          end
        end
      end
      if (bad) begin
        phase_next = PH_IDLE;
        half_flag_next = 1'b0;
        bit_count_next = '0;
        command_shift_next = '0;
        control_shift_next = '0;
      end
    end
  end

  // result
  always_comb begin
    emit = proc && (s_kind == KIND_EDGE) && done && !(lock_enable && locked);
    res_repeated = (toggle_bit == prior_toggle) && (cmd_new == prior_command);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_enable <= 1'b0;
      short_low <= SHORT_LOW_RST;
      short_high <= SHORT_HIGH_RST;
      long_low <= LONG_LOW_RST;
      long_high <= LONG_HIGH_RST;
      s_valid <= 1'b0;
      out_valid <= 1'b0;
      phase <= PH_IDLE;
      last_time <= '0;
      half_flag <= 1'b0;
      bit_count <= '0;
      command_shift <= '0;
      control_shift <= '0;
      toggle_bit <= 1'b0;
      prior_toggle <= 1'b0;
      prior_command <= '0;
      locked <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          CFG_LOCK_ENABLE: lock_enable <= wr_data[0];
          CFG_SHORT_LOW:   short_low <= wr_data;
          CFG_SHORT_HIGH:  short_high <= wr_data;
          CFG_LONG_LOW:    long_low <= wr_data;
          CFG_LONG_HIGH:   long_high <= wr_data;
          default:         lock_enable <= lock_enable;
        endcase
      end
      if (pin.valid && pin.ready) s_valid <= 1'b1;
      else if (proc) s_valid <= 1'b0;
      if (proc) begin
        phase <= phase_next;
        last_time <= last_time_next;
        half_flag <= half_flag_next;
        bit_count <= bit_count_next;
        command_shift <= command_shift_next;
        control_shift <= control_shift_next;
        toggle_bit <= toggle_bit_next;
        locked <= locked_next;
      end
      if (emit) begin
        prior_command <= cmd_new;
        prior_toggle <= toggle_bit;
      end
      if (emit) out_valid <= 1'b1;
      else if (frame.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pin.valid && pin.ready) begin
      s_kind <= pin.kind;
      s_ts <= pin.timestamp;
      s_level <= pin.level;
    end
    if (emit) begin
      out_command <= cmd_new;
      out_control <= ctl_new;
      out_repeated <= res_repeated;
    end
  end

  // outside the data phase the bit collection is empty
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase != PH_DATA |-> (half_flag == 1'b0 && bit_count == '0 &&
                          command_shift == '0 && control_shift == '0))
    else $error("bit collection not cleared outside data phase");

  // an unlock beat leaves the walk and the edge time alone
  a_unlock_stable: assert property (@(posedge clk) disable iff (rst)
    proc && s_kind == KIND_UNLOCK |=> $stable(phase) && $stable(last_time))
    else $error("unlock beat disturbed the frame walk");

  // the lock only closes together with a delivered frame
  a_lock_with_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(locked) |-> frame.valid)
    else $error("lock set without a result beat");

  // a new result beat comes only from a processed edge
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(proc && s_kind == KIND_EDGE))
    else $error("result beat without a processed edge");

endmodule
